>>> rtl/core/dzcpl_pkg.sv
// Shared types and constants for the DDS zero-crossing phase lock.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps
`default_nettype none

package dzcpl_pkg;

    typedef logic [15:0] t_word;
    typedef logic [27:0] t_tword;

    // Action codes on the input channel
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_BASE_FREQ = 3'd0;
    localparam logic [2:0] REG_WAVE_MODE = 3'd1;
    localparam logic [2:0] REG_MIN_FREQ  = 3'd2;
    localparam logic [2:0] REG_MAX_FREQ  = 3'd3;
    localparam logic [2:0] REG_ZERO_WIN  = 3'd4;
    localparam logic [2:0] REG_ERR_THR   = 3'd5;
    localparam logic [2:0] REG_PH_STEP   = 3'd6;
    localparam logic [2:0] REG_SRCH_DEC  = 3'd7;

    // Synthesizer command prefixes
    localparam t_word CMD_B28    = 16'h2000;
    localparam t_word CMD_FREQ0  = 16'h4000;
    localparam t_word CMD_PHASE0 = 16'hC000;

    localparam t_tword WORD28_MAX = 28'h0FF_FFFF | 28'hF00_0000;
    localparam logic [15:0] ZERO_RAW = 16'h8000;

    // Tracking gain, numerator over 2^16
    localparam logic signed [43:0] TRACK_GAIN = 44'sd655;

    // Word slots of one result bundle, lowest goes out first
    localparam int SLOT_PHASE  = 0;
    localparam int SLOT_ALT_B  = 1;
    localparam int SLOT_ALT_LO = 2;
    localparam int SLOT_ALT_HI = 3;
    localparam int SLOT_BAS_B  = 4;
    localparam int SLOT_BAS_LO = 5;
    localparam int SLOT_BAS_HI = 6;
    localparam int SLOTS       = 7;

endpackage : dzcpl_pkg

`default_nettype wire

>>> rtl/core/dds_zero_cross_phase_lock.sv
// One channel of a DDS phase lock: search, zero-crossing lock, tracking and
// fractional tuning word output. Depends on dzcpl_pkg.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall     | i_action, i_sample
//  out     | output    | o_out_valid / i_out_stall   | o_dds_word, o_locked, o_last_word
//  cfg     | input     | i_cfg_we (no wait)          | i_cfg_index, i_cfg_data
//
// An accepted transaction sits in the input register and is evaluated in one
// pass of logic when the result bundle is free; that edge updates all state and
// loads up to seven words into the bundle. The bundle serializer sends one word
// per cycle while i_out_stall is low; a transaction sends at most one phase word
// plus two groups of three tuning words, and a transaction that sends nothing
// loads nothing into the bundle. The input register takes the next
// transaction while the bundle drains. i_rst_n is synchronous: it empties both
// registers, idles the loop and restores the register defaults. A stall on the
// output freezes the word on the port and, once the input register is full,
// raises o_in_stall.
`timescale 1ns / 1ps
`default_nettype none

module dds_zero_cross_phase_lock
    import dzcpl_pkg::*;
#(
    parameter int STEP_MULT  = 4,
    parameter int RUN_LENGTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [27:0] i_cfg_data,

    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_sample,

    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      t_word       o_dds_word,
    output      logic        o_locked,
    output      logic        o_last_word
);

    localparam logic [7:0] HOLD_FULL = 8'(2 * STEP_MULT);
    localparam logic [7:0] TICK_WRAP = 8'(4 * STEP_MULT);
    localparam logic [7:0] RUN_LIM   = 8'(RUN_LENGTH);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_LOCKED = 2'd2
    } t_mode;

    function automatic t_tword sat_inc(input t_tword w);
        return (w == WORD28_MAX) ? w : w + 28'd1;
    endfunction

    function automatic t_tword sat_dec(input t_tword w);
        return (w == 28'd0) ? w : w - 28'd1;
    endfunction

    // Configuration registers
    t_tword      r_base_freq, r_min_freq, r_max_freq;
    logic [15:0] r_wave_mode;
    logic [14:0] r_zero_win, r_err_thr;
    logic [11:0] r_ph_step;
    logic [7:0]  r_srch_dec;

    // Input register
    logic        r_in_full;
    logic [1:0]  r_act;
    logic [15:0] r_smp;

    // Loop state
    t_mode              r_mode, n_mode;
    logic [11:0]        r_phase, n_phase;
    logic               r_armed, n_armed;
    logic [7:0]         r_dec, n_dec;
    logic [15:0]        r_prev, n_prev;
    logic signed [31:0] r_target, n_target;
    t_tword             r_base, n_base;
    t_tword             r_alt, n_alt;
    logic [7:0]         r_hold, n_hold;
    logic               r_toggle, n_toggle;
    logic [7:0]         r_hi_run, n_hi_run;
    logic [7:0]         r_lo_run, n_lo_run;
    logic [7:0]         r_tick, n_tick;

    // Result bundle
    logic [SLOTS-1:0] r_mask, n_mask;
    logic [11:0]      r_b_phase;
    t_tword           r_b_alt, r_b_base;
    logic             r_b_lock;

    // Datapath
    logic signed [15:0] w_v;
    logic signed [16:0] w_v17, w_win;
    logic               w_in_win;
    logic signed [33:0] w_d, w_thr;
    logic signed [43:0] w_p;
    logic               w_err_hi, w_err_lo;
    logic               w_has_phase, w_has_alt, w_has_base;
    logic               w_out_acc, w_move, w_in_acc;
    logic [SLOTS-1:0]   w_mask_rest;

    // Sample as signed volts count and window test
    assign w_v      = $signed({~r_smp[15], r_smp[14:0]});
    assign w_v17    = {w_v[15], w_v};
    assign w_win    = $signed({2'b00, r_zero_win});
    assign w_in_win = (w_v17 < w_win) && (w_v17 > -w_win);

    // Tracking error: d = v*2^16 - target, p = d*655
    assign w_d      = $signed({{2{w_v[15]}}, w_v, 16'h0000})
                      - $signed({{2{r_target[31]}}, r_target});
    assign w_p      = $signed({{10{w_d[33]}}, w_d}) * TRACK_GAIN;
    assign w_thr    = $signed({3'b000, r_err_thr, 16'h0000});
    assign w_err_hi = w_d > w_thr;
    assign w_err_lo = w_d < -w_thr;

    // Handshakes
    assign w_mask_rest = r_mask & (r_mask - SLOTS'(1));
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign w_move      = r_in_full && ((r_mask == '0) || (w_out_acc && (w_mask_rest == '0)));
    assign o_in_stall  = r_in_full && !w_move;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    // Next-state evaluation for the transaction in the input register
    always_comb begin
        n_mode      = r_mode;
        n_phase     = r_phase;
        n_armed     = r_armed;
        n_dec       = r_dec;
        n_prev      = r_prev;
        n_target    = r_target;
        n_base      = r_base;
        n_alt       = r_alt;
        n_hold      = r_hold;
        n_toggle    = r_toggle;
        n_hi_run    = r_hi_run;
        n_lo_run    = r_lo_run;
        n_tick      = r_tick;
        w_has_phase = 1'b0;
        w_has_alt   = 1'b0;
        w_has_base  = 1'b0;

        if (r_act == ACT_START) begin
            n_mode   = MODE_SEARCH;
            n_phase  = '0;
            n_armed  = 1'b0;
            n_dec    = r_srch_dec;
            n_prev   = ZERO_RAW;
            n_target = '0;
            n_base   = r_base_freq;
            n_alt    = sat_inc(r_base_freq);
            n_hold   = HOLD_FULL;
            n_toggle = 1'b0;
            n_hi_run = '0;
            n_lo_run = '0;
            n_tick   = '0;
        end else if (r_act == ACT_STOP) begin
            n_mode = MODE_IDLE;
        end else if (r_act == ACT_SAMPLE && r_mode != MODE_IDLE) begin
            unique case (r_mode)
                MODE_SEARCH: begin
                    if (r_dec != '0) begin
                        n_dec  = r_dec - 8'd1;
                        n_prev = r_smp;
                    end else begin
                        n_dec = r_srch_dec;
                        if (r_armed && (r_smp < r_prev) && w_in_win) begin
                            // falling crossing inside the window: lock
                            n_target = {w_v, 16'h0000};
                            n_mode   = MODE_LOCKED;
                            n_armed  = 1'b0;
                            n_hold   = HOLD_FULL;
                            n_hi_run = '0;
                            n_lo_run = '0;
                        end else begin
                            if (!r_armed && !w_v[15] && (w_v != '0))
                                n_armed = 1'b1;
                            n_phase     = r_phase + r_ph_step;
                            w_has_phase = 1'b1;
                            n_prev      = r_smp;
                        end
                    end
                end
                MODE_LOCKED: begin
                    n_target = r_target + {{4{w_p[43]}}, w_p[43:16]};
                    if (w_err_hi) begin
                        n_lo_run = '0;
                        n_hold   = (r_hold == '0) ? r_hold : r_hold - 8'd1;
                        n_hi_run = r_hi_run + 8'd1;
                        if (n_hi_run >= RUN_LIM) begin
                            n_base   = sat_inc(r_base);
                            n_alt    = sat_inc(r_alt);
                            n_hi_run = '0;
                            n_hold   = HOLD_FULL;
                        end
                    end else begin
                        n_hi_run = '0;
                    end
                    if (w_err_lo) begin
                        n_hi_run = '0;
                        n_hold   = (n_hold >= HOLD_FULL) ? HOLD_FULL : n_hold + 8'd1;
                        n_lo_run = r_lo_run + 8'd1;
                        if (n_lo_run >= RUN_LIM) begin
                            if (n_base != '0) begin
                                n_base = n_base - 28'd1;
                                n_alt  = sat_dec(n_alt);
                            end
                            n_lo_run = '0;
                            n_hold   = '0;
                        end
                    end else begin
                        n_lo_run = '0;
                    end
                    if (n_base < r_min_freq) begin
                        n_base = r_min_freq;
                        n_alt  = sat_inc(r_min_freq);
                    end
                    if (n_alt > r_max_freq) begin
                        n_alt  = r_max_freq;
                        n_base = sat_dec(r_max_freq);
                    end
                end
                default: ;
            endcase

            // Tick divider: alternate word (if pending), then base word
            n_tick = r_tick + 8'd1;
            if (n_tick >= TICK_WRAP) begin
                n_tick = '0;
                if (n_toggle) begin
                    w_has_alt = 1'b1;
                    n_toggle  = 1'b0;
                end
                if (n_hold != '0)
                    n_hold = n_hold - 8'd1;
                else
                    n_toggle = 1'b1;
                if (n_hold == '0 && !n_toggle && n_hi_run == '0 && n_lo_run == '0)
                    n_hold = HOLD_FULL;
                w_has_base = 1'b1;
            end
        end
    end

    always_comb begin
        n_mask = w_out_acc ? w_mask_rest : r_mask;
        if (w_move && (w_has_phase || w_has_alt || w_has_base))
            n_mask = {{3{w_has_base}}, {3{w_has_alt}}, w_has_phase};
    end

    // Output word: lowest pending slot
    assign o_out_valid = (r_mask != '0);
    assign o_locked    = r_b_lock;
    assign o_last_word = (w_mask_rest == '0);

    always_comb begin
        priority if (r_mask[SLOT_PHASE])
            o_dds_word = CMD_PHASE0 | {4'h0, r_b_phase};
        else if (r_mask[SLOT_ALT_B])
            o_dds_word = CMD_B28 | r_wave_mode;
        else if (r_mask[SLOT_ALT_LO])
            o_dds_word = CMD_FREQ0 | {2'b00, r_b_alt[13:0]};
        else if (r_mask[SLOT_ALT_HI])
            o_dds_word = CMD_FREQ0 | {2'b00, r_b_alt[27:14]};
        else if (r_mask[SLOT_BAS_B])
            o_dds_word = CMD_B28 | r_wave_mode;
        else if (r_mask[SLOT_BAS_LO])
            o_dds_word = CMD_FREQ0 | {2'b00, r_b_base[13:0]};
        else
            o_dds_word = CMD_FREQ0 | {2'b00, r_b_base[27:14]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_freq <= '0;
            r_wave_mode <= '0;
            r_min_freq  <= '0;
            r_max_freq  <= WORD28_MAX;
            r_zero_win  <= 15'd1000;
            r_err_thr   <= 15'd100;
            r_ph_step   <= 12'd11;
            r_srch_dec  <= 8'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BASE_FREQ: r_base_freq <= i_cfg_data;
                REG_WAVE_MODE: r_wave_mode <= i_cfg_data[15:0];
                REG_MIN_FREQ:  r_min_freq  <= i_cfg_data;
                REG_MAX_FREQ:  r_max_freq  <= i_cfg_data;
                REG_ZERO_WIN:  r_zero_win  <= i_cfg_data[14:0];
                REG_ERR_THR:   r_err_thr   <= i_cfg_data[14:0];
                REG_PH_STEP:   r_ph_step   <= i_cfg_data[11:0];
                REG_SRCH_DEC:  r_srch_dec  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_full <= 1'b0;
        end else if (w_in_acc) begin
            r_in_full <= 1'b1;
        end else if (w_move) begin
            r_in_full <= 1'b0;
        end
        if (w_in_acc) begin
            r_act <= i_action;
            r_smp <= i_sample;
        end
    end

    // Loop state and result bundle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_phase  <= '0;
            r_armed  <= 1'b0;
            r_dec    <= '0;
            r_prev   <= '0;
            r_target <= '0;
            r_base   <= '0;
            r_alt    <= '0;
            r_hold   <= '0;
            r_toggle <= 1'b0;
            r_hi_run <= '0;
            r_lo_run <= '0;
            r_tick   <= '0;
            r_mask   <= '0;
        end else begin
            r_mask <= n_mask;
            if (w_move) begin
                r_mode   <= n_mode;
                r_phase  <= n_phase;
                r_armed  <= n_armed;
                r_dec    <= n_dec;
                r_prev   <= n_prev;
                r_target <= n_target;
                r_base   <= n_base;
                r_alt    <= n_alt;
                r_hold   <= n_hold;
                r_toggle <= n_toggle;
                r_hi_run <= n_hi_run;
                r_lo_run <= n_lo_run;
                r_tick   <= n_tick;
            end
        end
        if (w_move && (w_has_phase || w_has_alt || w_has_base)) begin
            r_b_phase <= n_phase;
            r_b_alt   <= n_alt;
            r_b_base  <= n_base;
            r_b_lock  <= (n_mode == MODE_LOCKED);
        end
    end

endmodule : dds_zero_cross_phase_lock

`default_nettype wire

>>> rtl/core/dzcpl_checker.sv
// Port-level checks for dds_zero_cross_phase_lock, with its bind.
// Depends on dzcpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dzcpl_checker
    import dzcpl_pkg::*;
(
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  o_in_stall,
    input wire logic  o_out_valid,
    input wire logic  i_out_stall,
    input wire t_word o_dds_word,
    input wire logic  o_locked,
    input wire logic  o_last_word
);

    // Reset leaves both channels empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("channels not empty after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_dds_word) && $stable(o_locked) && $stable(o_last_word))
        else $error("output payload changed while stalled");

    // Words of one transaction leave back to back with one lock flag
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_word |=> o_out_valid && $stable(o_locked))
        else $error("transaction words split or lock flag changed");

endmodule : dzcpl_checker

bind dds_zero_cross_phase_lock dzcpl_checker u_dzcpl_checker (.*);

`default_nettype wire

>>> verif/tb_dds_zero_cross_phase_lock.sv
`timescale 1ns / 1ps
// Self-checking bench for dds_zero_cross_phase_lock: a directed stimulus table, then
// random search/lock sequences scored word by word against an in-bench loop model.
// Depends on dzcpl_pkg and the core RTL.

module tb_dds_zero_cross_phase_lock;
    import dzcpl_pkg::*;

    localparam int STEP_MULT       = 4;
    localparam int RUN_LENGTH      = 4;
    localparam int HOLD_FULL       = 2 * STEP_MULT;
    localparam int TICK_WRAP       = 4 * STEP_MULT;
    localparam int IDLE_LIMIT      = 1000;   // cycles with no transaction on either side
    localparam int DRAIN_CYCLES    = 20;     // covers a silent transaction still in flight
    localparam int ITEMS_PER_PHASE = 19;
    localparam int RANDOM_PHASES   = 5;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef enum logic [1:0] {LOOP_IDLE, LOOP_SEARCH, LOOP_LOCKED} t_loop_mode;

    typedef struct packed {
        t_word word;
        logic  locked;
        logic  last;
    } t_dds_out;

    typedef struct {
        logic [1:0]  act;
        logic [15:0] smp;
        bit          typed;   // expected words given in the row instead of the model
        int          n;
        t_word       word;
    } t_stim_row;

    // DUT ports; every input starts at a known value
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_index = REG_BASE_FREQ;
    logic [27:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_action    = ACT_SAMPLE;
    logic [15:0] i_sample    = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_word       o_dds_word;
    logic        o_locked;
    logic        o_last_word;

    dds_zero_cross_phase_lock #(
        .STEP_MULT  (STEP_MULT),
        .RUN_LENGTH (RUN_LENGTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dds_word  (o_dds_word),
        .o_locked    (o_locked),
        .o_last_word (o_last_word)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Register mirror, reset values
    t_tword      cfg_base     = '0;
    logic [15:0] cfg_wave     = '0;
    t_tword      cfg_min      = '0;
    t_tword      cfg_max      = WORD28_MAX;
    logic [14:0] cfg_zero_win = 15'd1000;
    logic [14:0] cfg_err_thr  = 15'd100;
    logic [11:0] cfg_step     = 12'd11;
    logic [7:0]  cfg_dec      = 8'd10;

    // Loop state mirror
    t_loop_mode  mode_q     = LOOP_IDLE;
    logic [11:0] phase_q    = '0;
    bit          armed_q    = 1'b0;
    logic [7:0]  dec_cnt_q  = '0;
    logic [15:0] prev_smp_q = '0;
    int          target_q   = 0;     // Q16.16 ADC counts
    t_tword      base_q     = '0;
    t_tword      alt_q      = '0;
    int          hold_q     = 0;
    bit          toggle_q   = 1'b0;
    int          high_run_q = 0;
    int          low_run_q  = 0;
    int          tick_q     = 0;

    t_word    burst[$];           // words caused by the current transaction
    t_dds_out pending_words[$];   // words still owed by the DUT, oldest first
    int       fail_count  = 0;
    int       idle_cycles = 0;
    int       stall_left  = 0;
    int       stall_roll;

    t_stim_row dir_rows [24] = '{
        '{ACT_SAMPLE, 16'h0000, 1'b1, 0, 16'h0000},                 // sample while idle
        '{ACT_UNUSED, 16'hFFFF, 1'b1, 0, 16'h0000},                 // unknown action
        '{ACT_STOP,   16'h0000, 1'b1, 0, 16'h0000},
        '{ACT_START,  16'h5555, 1'b1, 0, 16'h0000},
        '{ACT_SAMPLE, 16'h8000, 1'b1, 1, CMD_PHASE0 | 16'h0FFF},    // max step, unarmed
        '{ACT_SAMPLE, 16'hFFFF, 1'b1, 1, CMD_PHASE0 | 16'h0FFE},    // arms, phase wraps
        '{ACT_SAMPLE, 16'h8010, 1'b1, 0, 16'h0000},                 // falling in window: lock
        '{ACT_SAMPLE, 16'hFFFF, 1'b0, 0, 16'h0000},                 // high run, words saturate
        '{ACT_SAMPLE, 16'hFFFF, 1'b0, 0, 16'h0000},
        '{ACT_SAMPLE, 16'hFFFF, 1'b0, 0, 16'h0000},
        '{ACT_SAMPLE, 16'hFFFF, 1'b0, 0, 16'h0000},
        '{ACT_SAMPLE, 16'h0000, 1'b0, 0, 16'h0000},                 // low run, hold pinned
        '{ACT_SAMPLE, 16'h0000, 1'b0, 0, 16'h0000},
        '{ACT_SAMPLE, 16'h0000, 1'b0, 0, 16'h0000},
        '{ACT_SAMPLE, 16'h0000, 1'b0, 0, 16'h0000},
        '{ACT_SAMPLE, 16'h8010, 1'b0, 0, 16'h0000},
        '{ACT_SAMPLE, 16'h7FF0, 1'b0, 0, 16'h0000},
        '{ACT_SAMPLE, 16'h8000, 1'b0, 0, 16'h0000},
        '{ACT_SAMPLE, 16'hFFFF, 1'b0, 0, 16'h0000},
        '{ACT_SAMPLE, 16'h0000, 1'b0, 0, 16'h0000},                 // divider wraps here
        '{ACT_STOP,   16'hFFFF, 1'b1, 0, 16'h0000},
        '{ACT_SAMPLE, 16'h1234, 1'b1, 0, 16'h0000},                 // idle again
        '{ACT_START,  16'h0000, 1'b1, 0, 16'h0000},
        '{ACT_SAMPLE, 16'hFFFF, 1'b0, 0, 16'h0000}
    };

    function automatic t_tword sat_up(t_tword w);
        return (w == WORD28_MAX) ? w : w + 28'd1;
    endfunction

    function automatic t_tword sat_down(t_tword w);
        return (w == '0) ? w : w - 28'd1;
    endfunction

    // A tuning word goes out as control word plus low and high 14-bit halves
    task automatic push_tuning(t_tword w);
        burst.push_back(CMD_B28 | cfg_wave);
        burst.push_back(CMD_FREQ0 | {2'b00, w[13:0]});
        burst.push_back(CMD_FREQ0 | {2'b00, w[27:14]});
    endtask

    task automatic search_step(logic [15:0] smp);
        int sv;
        int win;
        bit locking;
        sv      = int'(smp) - int'(ZERO_RAW);
        win     = int'(cfg_zero_win);
        locking = 1'b0;
        // skipped samples still update the previous sample for the slope test
        if (dec_cnt_q != '0) begin
            dec_cnt_q--;
            prev_smp_q = smp;
            return;
        end
        dec_cnt_q = cfg_dec;
        if (armed_q) begin
            if (smp < prev_smp_q && sv < win && sv > -win) begin
                target_q   = sv * 65536;
                mode_q     = LOOP_LOCKED;
                armed_q    = 1'b0;
                hold_q     = HOLD_FULL;
                high_run_q = 0;
                low_run_q  = 0;
                locking    = 1'b1;
            end
        end else if (sv > 0) begin
            armed_q = 1'b1;
        end
        // the locking sample sends nothing and keeps the old previous sample
        if (!locking) begin
            phase_q = phase_q + cfg_step;
            burst.push_back(CMD_PHASE0 | {4'h0, phase_q});
            prev_smp_q = smp;
        end
    endtask

    task automatic track_step(logic [15:0] smp);
        longint diff;
        longint nudge;
        longint thr;
        diff     = (longint'(smp) - 32768) * 65536 - longint'(target_q);
        nudge    = (diff * longint'(TRACK_GAIN)) >>> 16;   // floor division
        target_q = int'(longint'(target_q) + nudge);
        thr      = longint'(cfg_err_thr) * 65536;

        if (diff > thr) begin
            low_run_q = 0;
            if (hold_q > 0) hold_q--;
            high_run_q++;
            if (high_run_q >= RUN_LENGTH) begin
                base_q     = sat_up(base_q);
                alt_q      = sat_up(alt_q);
                high_run_q = 0;
                hold_q     = HOLD_FULL;
            end
        end else begin
            high_run_q = 0;
        end
        if (diff < -thr) begin
            high_run_q = 0;
            hold_q++;
            if (hold_q > HOLD_FULL) hold_q = HOLD_FULL;
            low_run_q++;
            if (low_run_q >= RUN_LENGTH) begin
                if (base_q != '0) begin
                    base_q = base_q - 28'd1;
                    alt_q  = sat_down(alt_q);
                end
                low_run_q = 0;
                hold_q    = 0;
            end
        end else begin
            low_run_q = 0;
        end
        // limits; with min above max the max clamp wins
        if (base_q < cfg_min) begin
            base_q = cfg_min;
            alt_q  = sat_up(cfg_min);
        end
        if (alt_q > cfg_max) begin
            alt_q  = cfg_max;
            base_q = sat_down(cfg_max);
        end
    endtask

    task automatic divider_step();
        tick_q++;
        if (tick_q < TICK_WRAP) return;
        tick_q = 0;
        if (toggle_q) begin
            push_tuning(alt_q);
            toggle_q = 1'b0;
        end
        if (hold_q > 0) hold_q--;
        else toggle_q = 1'b1;
        if (hold_q == 0 && !toggle_q && high_run_q == 0 && low_run_q == 0)
            hold_q = HOLD_FULL;
        push_tuning(base_q);
    endtask

    // Advance the loop model by one transaction; words land in burst
    task automatic lock_loop_step(logic [1:0] act, logic [15:0] smp);
        burst.delete();
        case (act)
            ACT_START: begin
                mode_q     = LOOP_SEARCH;
                phase_q    = '0;
                armed_q    = 1'b0;
                dec_cnt_q  = cfg_dec;
                prev_smp_q = ZERO_RAW;
                target_q   = 0;
                base_q     = cfg_base;
                alt_q      = sat_up(cfg_base);
                hold_q     = HOLD_FULL;
                toggle_q   = 1'b0;
                high_run_q = 0;
                low_run_q  = 0;
                tick_q     = 0;
            end
            ACT_STOP: mode_q = LOOP_IDLE;
            ACT_SAMPLE: begin
                if (mode_q != LOOP_IDLE) begin
                    if (mode_q == LOOP_SEARCH) search_step(smp);
                    else track_step(smp);
                    divider_step();
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_burst();
        t_dds_out entry;
        foreach (burst[k]) begin
            entry.word   = burst[k];
            entry.locked = (mode_q == LOOP_LOCKED);
            entry.last   = (k == burst.size() - 1);
            pending_words.push_back(entry);
        end
    endtask

    // Mostly back to back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    // Offer one transaction; returns at the edge that accepts it
    task automatic send_txn(logic [1:0] act, logic [15:0] smp, bit typed, int n, t_word word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_sample   <= smp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        lock_loop_step(act, smp);
        if (typed) begin
            burst.delete();
            if (n > 0) burst.push_back(word);
        end
        queue_burst();
    endtask

    // Hold the sender until every owed word is out, then let the pipe settle
    task automatic drain_loop();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [27:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_BASE_FREQ: cfg_base     = data;
            REG_WAVE_MODE: cfg_wave     = data[15:0];
            REG_MIN_FREQ:  cfg_min      = data;
            REG_MAX_FREQ:  cfg_max      = data;
            REG_ZERO_WIN:  cfg_zero_win = data[14:0];
            REG_ERR_THR:   cfg_err_thr  = data[14:0];
            REG_PH_STEP:   cfg_step     = data[11:0];
            REG_SRCH_DEC:  cfg_dec      = data[7:0];
            default: ;
        endcase
    endtask

    // Every register on every phase; phases 0, 2 and 3 pin the extremes
    task automatic configure_phase(int ph);
        logic [27:0] vals [8];
        t_tword b;
        case (ph)
            0: vals = '{WORD28_MAX, 28'h000FFFF, 28'd0, WORD28_MAX,
                        28'd1000, 28'd100, 28'hFFF, 28'd0};
            // inverted limits, zero threshold, widest window, zero step
            2: vals = '{28'd0, 28'd0, WORD28_MAX, 28'd1,
                        28'h7FFF, 28'd0, 28'd0, 28'd0};
            // window closed, max threshold, max decimation
            3: vals = '{28'd0, 28'h0005555, 28'd0, WORD28_MAX,
                        28'd0, 28'h7FFF, 28'hFFF, 28'hFF};
            // tight limits around a small base word
            4: begin
                b    = 28'($urandom_range(0, 2000));
                vals = '{b, 28'($urandom_range(0, 65535)), 28'($urandom_range(0, b)),
                         b + 28'($urandom_range(1, 4)), 28'($urandom_range(300, 3000)),
                         28'($urandom_range(0, 60)), 28'($urandom_range(1, 4095)),
                         28'($urandom_range(0, 2))};
            end
            default: vals = '{28'($urandom()), 28'($urandom_range(0, 65535)), 28'd0,
                              WORD28_MAX, 28'($urandom_range(200, 4000)),
                              28'($urandom_range(0, 400)), 28'($urandom_range(0, 4095)),
                              28'($urandom_range(0, 3))};
        endcase
        write_reg(REG_BASE_FREQ, vals[REG_BASE_FREQ]);
        write_reg(REG_WAVE_MODE, vals[REG_WAVE_MODE]);
        write_reg(REG_MIN_FREQ,  vals[REG_MIN_FREQ]);
        write_reg(REG_MAX_FREQ,  vals[REG_MAX_FREQ]);
        write_reg(REG_ZERO_WIN,  vals[REG_ZERO_WIN]);
        write_reg(REG_ERR_THR,   vals[REG_ERR_THR]);
        write_reg(REG_PH_STEP,   vals[REG_PH_STEP]);
        write_reg(REG_SRCH_DEC,  vals[REG_SRCH_DEC]);
        i_cfg_we <= 1'b0;
    endtask

    // Start, then a triangle wave while searching and biased error runs once
    // locked; a tenth of the samples are raw noise, a few stops and bad actions.
    task automatic run_random_phase(int ph);
        int count;
        int r;
        int amp;
        int tri_pos;
        int run_dir;
        int v;
        bit ignored;
        logic [1:0] act;
        logic [15:0] smp;
        count   = 0;
        amp     = 1000;
        tri_pos = 0;
        run_dir = 1;
        while (count < ITEMS_PER_PHASE) begin
            r   = $urandom_range(0, 99);
            smp = 16'($urandom_range(0, 65535));
            if (count == 0 || (mode_q == LOOP_IDLE && r >= 40) || r < 3) begin
                act     = ACT_START;
                amp     = ($urandom_range(0, 9) == 0) ? $urandom_range(8000, 32000)
                                                      : $urandom_range(300, 8000);
                tri_pos = $urandom_range(0, 63);
            end else if (r < 6) begin
                act = ACT_STOP;
            end else if (r < 9) begin
                act = ACT_UNUSED;
            end else begin
                act = ACT_SAMPLE;
                if (r < 90 && mode_q == LOOP_SEARCH) begin
                    tri_pos = (tri_pos + $urandom_range(1, 3)) % 64;
                    v       = (tri_pos < 32) ? 16 - tri_pos : tri_pos - 48;
                    smp     = 16'(32768 + v * amp / 16);
                end else if (r < 90 && mode_q == LOOP_LOCKED) begin
                    if ($urandom_range(0, 3) == 0) run_dir = int'($urandom_range(0, 2)) - 1;
                    v = (target_q >>> 16)
                        + run_dir * (int'(cfg_err_thr) + int'($urandom_range(1, 300)))
                        + int'($urandom_range(0, 20)) - 10;
                    if (v > 32767) v = 32767;
                    if (v < -32768) v = -32768;
                    smp = 16'(v + 32768);
                end
            end
            ignored = (act == ACT_UNUSED) || (act == ACT_SAMPLE && mode_q == LOOP_IDLE);
            send_txn(act, smp, 1'b0, 0, '0);
            if (!ignored) count++;
            if ((ph == 1 && count == ITEMS_PER_PHASE / 2) || $urandom_range(0, 39) == 0)
                drain_loop();
        end
    endtask

    // Output stall: long open stretches, short stalls, the odd long one
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 50) begin
                i_out_stall <= 1'b0;
                stall_left  <= $urandom_range(0, 20);
            end else if (stall_roll < 85) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(0, 2);
            end else if (stall_roll < 95) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(3, 7);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(19, 39);
            end
        end
    end

    // Score each word leaving the DUT against the oldest owed word
    always @(posedge i_clk) begin
        t_dds_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, o_dds_word);
                fail_count++;
            end else begin
                want = pending_words.pop_front();
                if (o_dds_word !== want.word) begin
                    $display("%0t: dds_word expected %h got %h", $time, want.word, o_dds_word);
                    fail_count++;
                end
                if (o_locked !== want.locked) begin
                    $display("%0t: locked expected %b got %b", $time, want.locked, o_locked);
                    fail_count++;
                end
                if (o_last_word !== want.last) begin
                    $display("%0t: last_word expected %b got %b", $time, want.last,
                             o_last_word);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without a transaction on either side ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d words owed", $time,
                     IDLE_LIMIT, pending_words.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure_phase(0);
        foreach (dir_rows[k])
            send_txn(dir_rows[k].act, dir_rows[k].smp, dir_rows[k].typed, dir_rows[k].n,
                     dir_rows[k].word);

        for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
            drain_loop();
            configure_phase(ph);
            run_random_phase(ph);
        end
        drain_loop();

        if (fail_count == 0 && pending_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
